/* sv/pmme_pkg.sv */
// ----------------------------------------------------------------------------
// pmme_pkg: shared types and helpers of the packed multibit map engine
// Field widths, command and register codes, sequencer states, and the
// word-level helpers of the compare unit.
// ----------------------------------------------------------------------------
package pmme_pkg;

  localparam int unsigned WordW         = 32;
  localparam int unsigned CmdW          = 3;
  localparam int unsigned IdxW          = 12;
  localparam int unsigned ValW          = 8;
  localparam int unsigned CntW          = 13;
  localparam int unsigned CodeW         = 2;
  localparam int unsigned SlotW         = 5;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned RowCalcW      = 14;
  localparam int unsigned FiCalcW       = 18;
  localparam int unsigned DefStoreWords = 128;

  localparam logic [CodeW-1:0] WidthCodeRst  = 2'd0;
  localparam logic [CntW-1:0]  EntryCountRst = 13'd4096;

  typedef enum logic [CmdW-1:0] {
    CMD_SET   = 3'd0,
    CMD_GET   = 3'd1,
    CMD_FIND  = 3'd2,
    CMD_RUN   = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH_CODE  = 1'b0,
    CFG_ENTRY_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_CLEAR,
    ST_RESP
  } state_e;

  function automatic logic [ValW-1:0] entry_mask(input logic [CodeW-1:0] code);
    logic [ValW-1:0] m;
    case (code)
      2'd0:    m = 8'h01;
      2'd1:    m = 8'h03;
      2'd2:    m = 8'h0F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  // One bit per entry slot of the word, set where the entry equals want.
  function automatic logic [WordW-1:0] match_vec(input logic [WordW-1:0] w,
                                                  input logic [CodeW-1:0] code,
                                                  input logic [ValW-1:0]  want);
    logic [WordW-1:0] eq;
    eq = '0;
    case (code)
      2'd0: for (int j = 0; j < 32; j++) eq[j] = (w[j] == want[0]);
      2'd1: for (int j = 0; j < 16; j++) eq[j] = (w[2*j +: 2] == want[1:0]);
      2'd2: for (int j = 0; j < 8; j++)  eq[j] = (w[4*j +: 4] == want[3:0]);
      default: for (int j = 0; j < 4; j++) eq[j] = (w[8*j +: 8] == want);
    endcase
    return eq;
  endfunction

  // Position of the lowest set bit, 32 when none is set.
  function automatic logic [SlotW:0] first_one(input logic [WordW-1:0] v);
    logic [SlotW:0] r;
    r = 6'd32;
    for (int j = WordW - 1; j >= 0; j--) begin
      if (v[j]) r = 6'(j);
    end
    return r;
  endfunction

  function automatic logic [ValW-1:0] extract(input logic [WordW-1:0]  w,
                                              input logic [CodeW-1:0]  code,
                                              input logic [SlotW-1:0]  slot);
    logic [SlotW-1:0] sh;
    sh = SlotW'(slot << code);
    return ValW'(w >> sh) & entry_mask(code);
  endfunction

  function automatic logic [WordW-1:0] insert(input logic [WordW-1:0] w,
                                              input logic [CodeW-1:0] code,
                                              input logic [SlotW-1:0] slot,
                                              input logic [ValW-1:0]  val);
    logic [SlotW-1:0] sh;
    logic [WordW-1:0] m;
    sh = SlotW'(slot << code);
    m  = WordW'(entry_mask(code)) << sh;
    return (w & ~m) | ((WordW'(val & entry_mask(code))) << sh);
  endfunction

endpackage

/* sv/packed_multibit_map_engine.sv */
// ----------------------------------------------------------------------------
// packed_multibit_map_engine: packed 1/2/4/8-bit entry map with search
// Set, get, find-first-equal, run-length test and clear over a word store,
// driven by a small sequencer around one word-wide compare unit.
// ----------------------------------------------------------------------------
// The store holds STORE_WORDS 32-bit words of packed entries, lowest entry in
// the low bits. After reset the block clears the whole store, one word a
// cycle, before it takes its first item (configuration writes are taken
// during that pass). One item is in work at a time; the result sits in an
// output register, so the next item is taken while it waits. Set and get do
// one store read and one evaluation step (set writes the word back); find
// and run test do one store read, then one pass through the compare unit,
// per word scanned, up to the last used word; clear writes each used word.
// An out-of-range index or an unused command answers without a store access.
// ----------------------------------------------------------------------------
module packed_multibit_map_engine import pmme_pkg::*; #(
  parameter int unsigned STORE_WORDS = DefStoreWords
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CntW-1:0]     cfg_data_i,
  // input items
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CmdW-1:0]     cmd_i,
  input  logic [IdxW-1:0]     entry_index_i,
  input  logic [ValW-1:0]     entry_value_i,
  input  logic [CntW-1:0]     run_limit_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                status_o,
  output logic [ValW-1:0]     read_value_o,
  output logic                found_o,
  output logic [IdxW-1:0]     found_index_o,
  output logic [CntW-1:0]     match_count_o
);

  localparam int unsigned AddrW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int unsigned RowW  = $clog2(STORE_WORDS + 1);

  // configuration
  logic [CodeW-1:0] width_code_q;
  logic [CntW-1:0]  entry_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_code_q  <= WidthCodeRst;
      entry_count_q <= EntryCountRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH_CODE:  width_code_q  <= cfg_data_i[CodeW-1:0];
        CFG_ENTRY_COUNT: entry_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // geometry: entries per word is 32 >> code, so index / cols is a shift
  logic [2:0]          row_shift;
  logic [SlotW-1:0]    cols_m1;
  logic [RowCalcW-1:0] rows_raw;
  logic [RowW-1:0]     rows_used;
  logic [IdxW-1:0]     idx_row;
  logic                idx_oor;
  logic [SlotW-1:0]    idx_slot;
  logic [ValW-1:0]     want_in;

  always_comb begin
    row_shift = 3'd5 - {1'b0, width_code_q};
    cols_m1   = 5'h1F >> width_code_q;
    // ceil(count / cols), then clamped to the store size
    rows_raw  = ({1'b0, entry_count_q} + RowCalcW'(cols_m1)) >> row_shift;
    rows_used = (rows_raw > RowCalcW'(STORE_WORDS)) ? RowW'(STORE_WORDS)
                                                    : rows_raw[RowW-1:0];
    idx_row   = entry_index_i >> row_shift;
    idx_oor   = {2'b00, idx_row} >= RowCalcW'(rows_used);
    idx_slot  = entry_index_i[SlotW-1:0] & cols_m1;
    want_in   = entry_value_i & entry_mask(width_code_q);
  end

  // word store
  logic [WordW-1:0] mem [STORE_WORDS];
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [WordW-1:0] mem_wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  // sequencer and datapath registers
  state_e          state_q, state_d;
  cmd_e            cmd_q, cmd_d;
  logic [RowW-1:0] row_q, row_d;
  logic [RowW-1:0] rows_q, rows_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [ValW-1:0] want_q, want_d;
  logic [CntW-1:0] lim_q, lim_d;
  logic [CntW-1:0] count_q, count_d;
  logic            res_status_q, res_status_d;
  logic [ValW-1:0] res_rv_q, res_rv_d;
  logic            res_found_q, res_found_d;
  logic [IdxW-1:0] res_fi_q, res_fi_d;

  logic            out_valid_q, out_valid_d;
  logic            status_q, status_d;
  logic [ValW-1:0] read_value_q, read_value_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] found_index_q, found_index_d;
  logic [CntW-1:0] match_count_q, match_count_d;

  // shared compare unit: one stored word against the wanted value
  logic [WordW-1:0]    eq_v, eq_sh;
  logic [SlotW:0]      avail, hit_pos, run_raw, run_len;
  logic                hit, run_end, last_row;
  logic [SlotW-1:0]    hit_slot;
  logic [FiCalcW-1:0]  fi_wide;
  logic [RowCalcW-1:0] run_sum;
  logic [RowW-1:0]     row_inc;

  always_comb begin
    eq_v     = match_vec(rdata_q, width_code_q, want_q);
    eq_sh    = eq_v >> slot_q;
    avail    = {1'b0, cols_m1} + 6'd1 - {1'b0, slot_q};
    hit_pos  = first_one(eq_sh);
    hit      = hit_pos < avail;
    hit_slot = slot_q + hit_pos[SlotW-1:0];
    fi_wide  = (FiCalcW'(row_q) << row_shift) | FiCalcW'(hit_slot);
    run_raw  = first_one(~eq_sh);
    run_len  = (run_raw > avail) ? avail : run_raw;
    run_end  = run_len < avail;
    run_sum  = RowCalcW'(count_q) + RowCalcW'(run_len);
    row_inc  = row_q + 1'b1;
    last_row = row_inc == rows_q;
  end

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    row_d         = row_q;
    rows_d        = rows_q;
    slot_d        = slot_q;
    want_d        = want_q;
    lim_d         = lim_q;
    count_d       = count_q;
    res_status_d  = res_status_q;
    res_rv_d      = res_rv_q;
    res_found_d   = res_found_q;
    res_fi_d      = res_fi_q;
    out_valid_d   = out_valid_q;
    status_d      = status_q;
    read_value_d  = read_value_q;
    found_d       = found_q;
    found_index_d = found_index_q;
    match_count_d = match_count_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = row_q[AddrW-1:0];
    mem_raddr     = row_q[AddrW-1:0];
    mem_wdata     = '0;
    in_ready_o    = 1'b0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      ST_INIT: begin
        // post-reset zeroing of every word
        mem_we = 1'b1;
        if (row_q == RowW'(STORE_WORDS - 1)) begin
          row_d   = '0;
          state_d = ST_IDLE;
        end else begin
          row_d = row_inc;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d        = cmd_e'(cmd_i);
          rows_d       = rows_used;
          row_d        = RowW'(idx_row);
          slot_d       = idx_slot;
          want_d       = want_in;
          lim_d        = run_limit_i;
          count_d      = '0;
          res_status_d = 1'b0;
          res_rv_d     = '0;
          res_found_d  = 1'b0;
          res_fi_d     = '0;
          case (cmd_e'(cmd_i))
            CMD_SET, CMD_GET, CMD_FIND, CMD_RUN: begin
              if (idx_oor) begin
                res_status_d = 1'b1;
                state_d      = ST_RESP;
              end else if (cmd_e'(cmd_i) == CMD_RUN && run_limit_i == '0) begin
                state_d = ST_RESP;
              end else begin
                state_d = ST_READ;
              end
            end
            CMD_CLEAR: begin
              row_d   = '0;
              state_d = (rows_used == '0) ? ST_RESP : ST_CLEAR;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end

      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_EVAL;
      end

      ST_EVAL: begin
        state_d = ST_RESP;
        case (cmd_q)
          CMD_SET: begin
            mem_we    = 1'b1;
            mem_wdata = insert(rdata_q, width_code_q, slot_q, want_q);
          end
          CMD_GET: res_rv_d = extract(rdata_q, width_code_q, slot_q);
          CMD_FIND: begin
            if (hit) begin
              res_found_d = 1'b1;
              res_fi_d    = fi_wide[IdxW-1:0];
            end else if (!last_row) begin
              row_d   = row_inc;
              slot_d  = '0;
              state_d = ST_READ;
            end
          end
          CMD_RUN: begin
            if (run_sum >= RowCalcW'(lim_q)) begin
              count_d = lim_q;
            end else begin
              count_d = run_sum[CntW-1:0];
              if (!run_end && !last_row) begin
                row_d   = row_inc;
                slot_d  = '0;
                state_d = ST_READ;
              end
            end
          end
          default: ;
        endcase
      end

      ST_CLEAR: begin
        mem_we = 1'b1;
        if (last_row) state_d = ST_RESP;
        else          row_d   = row_inc;
      end

      ST_RESP: begin
        // hand over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          status_d      = res_status_q;
          read_value_d  = res_rv_q;
          found_d       = res_found_q;
          found_index_d = res_fi_q;
          match_count_d = count_q;
          state_d       = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    rows_q        <= rows_d;
    slot_q        <= slot_d;
    want_q        <= want_d;
    lim_q         <= lim_d;
    count_q       <= count_d;
    res_status_q  <= res_status_d;
    res_rv_q      <= res_rv_d;
    res_found_q   <= res_found_d;
    res_fi_q      <= res_fi_d;
    status_q      <= status_d;
    read_value_q  <= read_value_d;
    found_q       <= found_d;
    found_index_q <= found_index_d;
    match_count_q <= match_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_value_o  = read_value_q;
  assign found_o       = found_q;
  assign found_index_o = found_index_q;
  assign match_count_o = match_count_q;

endmodule
